>>> design/hria_pkg.sv
// Package for the heart rate interval averager: widths, constants and the
// microcode program (control word type, op and branch codes, program table).
// Depends on nothing; every design file refers to it by scoped names.
package hria_pkg;

	// Field widths of the channels.
	localparam int IR_W   = 18;
	localparam int TIME_W = 32;
	localparam int BPM_W  = 16;
	localparam int AVG_W  = 8;

	// Shared serial divider widths: dividend 15360000 fits 24 bits, divisor
	// is at most 1999 (11 bits), the partial remainder needs one bit more.
	localparam int DVD_W = 24;
	localparam int DVS_W = 11;
	localparam int REM_W = 12;
	localparam int DCNT_W = 5;
	localparam logic [DCNT_W-1:0] DIV_STEPS = 5'd24;

	// Rate arithmetic constants: 60000 ms per minute in Q8.8.
	localparam logic [DVD_W-1:0] RATE_Q8_NUM = 24'd15360000;
	localparam logic [TIME_W-1:0] MIN_INTERVAL = 32'd236;
	localparam logic [TIME_W-1:0] MAX_INTERVAL = 32'd1999;
	localparam logic [IR_W-1:0] THRESH_RESET = 18'd5000;

	// Microcode sequencer.
	localparam int STEP_W = 4;
	localparam int OP_W = 4;
	localparam int COND_W = 3;

	// Datapath operations.
	localparam logic [OP_W-1:0] OP_WAIT     = 4'd0;
	localparam logic [OP_W-1:0] OP_DIFF     = 4'd1;
	localparam logic [OP_W-1:0] OP_LOAD_BPM = 4'd2;
	localparam logic [OP_W-1:0] OP_DIV      = 4'd3;
	localparam logic [OP_W-1:0] OP_STORE    = 4'd4;
	localparam logic [OP_W-1:0] OP_SUM      = 4'd5;
	localparam logic [OP_W-1:0] OP_LOAD_AVG = 4'd6;
	localparam logic [OP_W-1:0] OP_AVG      = 4'd7;
	localparam logic [OP_W-1:0] OP_FINISH   = 4'd8;

	// Branch conditions: true takes jump_true, false takes jump_false.
	localparam logic [COND_W-1:0] C_ALWAYS   = 3'd0;
	localparam logic [COND_W-1:0] C_ACCEPT   = 3'd1;
	localparam logic [COND_W-1:0] C_KEEP     = 3'd2;
	localparam logic [COND_W-1:0] C_DIV_BUSY = 3'd3;
	localparam logic [COND_W-1:0] C_SUM_MORE = 3'd4;
	localparam logic [COND_W-1:0] C_OUT_FULL = 3'd5;

	// Step addresses of the program.
	localparam logic [STEP_W-1:0] S_WAIT     = 4'd0;
	localparam logic [STEP_W-1:0] S_DIFF     = 4'd1;
	localparam logic [STEP_W-1:0] S_RANGE    = 4'd2;
	localparam logic [STEP_W-1:0] S_DIV_BPM  = 4'd3;
	localparam logic [STEP_W-1:0] S_STORE    = 4'd4;
	localparam logic [STEP_W-1:0] S_SUM      = 4'd5;
	localparam logic [STEP_W-1:0] S_LOAD_AVG = 4'd6;
	localparam logic [STEP_W-1:0] S_DIV_AVG  = 4'd7;
	localparam logic [STEP_W-1:0] S_AVG      = 4'd8;
	localparam logic [STEP_W-1:0] S_FINISH   = 4'd9;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [COND_W-1:0] cond;
		logic [STEP_W-1:0] jump_true;
		logic [STEP_W-1:0] jump_false;
	} ucode_t;

	// Program table: one control word per step.
	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t w;
		case (step)
			S_WAIT:     w = '{OP_WAIT,     C_ACCEPT,   S_DIFF,     S_WAIT};
			S_DIFF:     w = '{OP_DIFF,     C_ALWAYS,   S_RANGE,    S_RANGE};
			S_RANGE:    w = '{OP_LOAD_BPM, C_KEEP,     S_DIV_BPM,  S_FINISH};
			S_DIV_BPM:  w = '{OP_DIV,      C_DIV_BUSY, S_DIV_BPM,  S_STORE};
			S_STORE:    w = '{OP_STORE,    C_ALWAYS,   S_SUM,      S_SUM};
			S_SUM:      w = '{OP_SUM,      C_SUM_MORE, S_SUM,      S_LOAD_AVG};
			S_LOAD_AVG: w = '{OP_LOAD_AVG, C_ALWAYS,   S_DIV_AVG,  S_DIV_AVG};
			S_DIV_AVG:  w = '{OP_DIV,      C_DIV_BUSY, S_DIV_AVG,  S_AVG};
			S_AVG:      w = '{OP_AVG,      C_ALWAYS,   S_FINISH,   S_FINISH};
			S_FINISH:   w = '{OP_FINISH,   C_OUT_FULL, S_FINISH,   S_WAIT};
			default:    w = '{OP_WAIT,     C_ALWAYS,   S_WAIT,     S_WAIT};
		endcase
		return w;
	endfunction

endpackage

>>> design/hria_if.sv
// Valid/ready channel interfaces of the heart rate interval averager:
// sample items, result items and the threshold write channel.
// Depends on hria_pkg for the field widths.
interface hria_sample_if;
	logic                         valid;
	logic                         ready;
	logic [hria_pkg::IR_W-1:0]    ir_sample;
	logic                         beat_seen;
	logic [hria_pkg::TIME_W-1:0]  time_ms;

	modport source (output valid, ir_sample, beat_seen, time_ms, input ready);
	modport sink (input valid, ir_sample, beat_seen, time_ms, output ready);
endinterface

interface hria_result_if;
	logic                        valid;
	logic                        ready;
	logic                        finger_present;
	logic                        beat_accepted;
	logic [hria_pkg::BPM_W-1:0]  bpm_q8;
	logic [hria_pkg::AVG_W-1:0]  average_bpm;

	modport source (output valid, finger_present, beat_accepted, bpm_q8, average_bpm,
		input ready);
	modport sink (input valid, finger_present, beat_accepted, bpm_q8, average_bpm,
		output ready);
endinterface

interface hria_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [hria_pkg::IR_W-1:0]  finger_threshold;

	modport source (output valid, finger_threshold, input ready);
	modport sink (input valid, finger_threshold, output ready);
endinterface

>>> design/heart_rate_interval_averager.sv
// Steps: an item without a kept beat goes through the interval and range steps to the finish step; a kept
// beat also takes the store, sum and average steps and two 24-step passes of the serial divider.
// Throughput: one item at a time; the next is taken once the result is in the output register.
// The output register holds a result until taken while the next item is accepted.
// Reset (arst_n low, asynchronous): history cleared, threshold 5000, no result pending.
// Depends on hria_pkg and the interfaces in hria_if.
module heart_rate_interval_averager #(
	parameter int RING_DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	hria_sample_if.sink          samples,
	hria_result_if.source        results,
	hria_cfg_if.sink             cfg
);

	localparam int CNT_W = $clog2(RING_DEPTH + 1);
	localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int SUM_W = hria_pkg::AVG_W + CNT_W;
	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(RING_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

	// Sequencer and control state.
	logic [hria_pkg::STEP_W-1:0] step_q;
	hria_pkg::ucode_t            uc;
	logic                        cond_true;
	logic [hria_pkg::IR_W-1:0]   thresh_q;
	logic [CNT_W-1:0]            filled_q;
	logic [IDX_W-1:0]            ring_idx_q;
	logic [hria_pkg::TIME_W-1:0] last_q;
	logic [hria_pkg::BPM_W-1:0]  bpm_q;
	logic [hria_pkg::AVG_W-1:0]  avg_q;
	logic                        accepted_q;
	logic                        out_valid_q;

	// Datapath registers.
	logic [hria_pkg::IR_W-1:0]   ir_q;
	logic                        beat_q;
	logic [hria_pkg::TIME_W-1:0] time_q;
	logic [hria_pkg::TIME_W-1:0] interval_q;
	logic [hria_pkg::DVD_W-1:0]  dvd_q;
	logic [hria_pkg::DVS_W-1:0]  dvs_q;
	logic [hria_pkg::REM_W-1:0]  rem_q;
	logic [hria_pkg::DCNT_W-1:0] div_cnt_q;
	logic [SUM_W-1:0]            sum_q;
	logic [IDX_W-1:0]            sum_idx_q;
	logic [7:0]                  ring_q [RING_DEPTH];
	logic                        out_present_q;
	logic                        out_accepted_q;
	logic [hria_pkg::BPM_W-1:0]  out_bpm_q;
	logic [hria_pkg::AVG_W-1:0]  out_avg_q;

	logic                        in_accept;
	logic                        keep;
	logic                        present;
	logic                        out_full;
	logic                        finish_go;
	logic [hria_pkg::REM_W-1:0]  rem_shift;
	logic                        rem_ge;
	logic [CNT_W-1:0]            sum_next_cnt;

	assign uc = hria_pkg::ucode_rom(step_q);

	// Handshakes.
	assign samples.ready = (uc.op == hria_pkg::OP_WAIT);
	assign in_accept = samples.valid && samples.ready;
	assign cfg.ready = 1'b1;
	assign out_full = out_valid_q && !results.ready;
	assign finish_go = (uc.op == hria_pkg::OP_FINISH) && !out_full;

	// Beat qualification and finger detection.
	assign keep = beat_q && (last_q != '0) && (interval_q >= hria_pkg::MIN_INTERVAL)
		&& (interval_q <= hria_pkg::MAX_INTERVAL);
	assign present = (ir_q >= thresh_q);

	// One restoring division step.
	assign rem_shift = {rem_q[hria_pkg::REM_W-2:0], dvd_q[hria_pkg::DVD_W-1]};
	assign rem_ge = (rem_shift >= {1'b0, dvs_q});

	assign sum_next_cnt = CNT_W'(sum_idx_q) + CNT_W'(1);

	// Branch condition select.
	always_comb begin
		case (uc.cond)
			hria_pkg::C_ALWAYS:   cond_true = 1'b1;
			hria_pkg::C_ACCEPT:   cond_true = in_accept;
			hria_pkg::C_KEEP:     cond_true = keep;
			hria_pkg::C_DIV_BUSY: cond_true = (div_cnt_q != hria_pkg::DCNT_W'(1));
			hria_pkg::C_SUM_MORE: cond_true = (sum_next_cnt < filled_q);
			hria_pkg::C_OUT_FULL: cond_true = out_full;
			default:              cond_true = 1'b1;
		endcase
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= hria_pkg::S_WAIT;
		end else begin
			step_q <= cond_true ? uc.jump_true : uc.jump_false;
		end
	end

	// Threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= hria_pkg::THRESH_RESET;
		end else if (cfg.valid && cfg.ready) begin
			thresh_q <= cfg.finger_threshold;
		end
	end

	// History state: ring position, fill count, last beat time, held rates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
			ring_idx_q <= '0;
			last_q <= '0;
			bpm_q <= '0;
			avg_q <= '0;
			accepted_q <= 1'b0;
		end else begin
			case (uc.op)
				hria_pkg::OP_WAIT: begin
					accepted_q <= 1'b0;
				end
				hria_pkg::OP_STORE: begin
					bpm_q <= dvd_q[hria_pkg::BPM_W-1:0];
					ring_idx_q <= (ring_idx_q == LAST_IDX) ? '0 : ring_idx_q + IDX_W'(1);
					if (filled_q != FULL_COUNT) begin
						filled_q <= filled_q + CNT_W'(1);
					end
				end
				hria_pkg::OP_AVG: begin
					avg_q <= dvd_q[hria_pkg::AVG_W-1:0];
					accepted_q <= 1'b1;
				end
				hria_pkg::OP_FINISH: begin
					if (finish_go) begin
						if (!present) begin
							filled_q <= '0;
							ring_idx_q <= '0;
							last_q <= '0;
							bpm_q <= '0;
							avg_q <= '0;
						end else if (beat_q) begin
							last_q <= time_q;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish_go) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Datapath: item capture, interval, shared divider, ring and sum.
	always_ff @(posedge clk) begin
		case (uc.op)
			hria_pkg::OP_WAIT: begin
				if (in_accept) begin
					ir_q <= samples.ir_sample;
					beat_q <= samples.beat_seen;
					time_q <= samples.time_ms;
				end
			end
			hria_pkg::OP_DIFF: begin
				interval_q <= time_q - last_q;
			end
			hria_pkg::OP_LOAD_BPM: begin
				dvd_q <= hria_pkg::RATE_Q8_NUM;
				dvs_q <= interval_q[hria_pkg::DVS_W-1:0];
				rem_q <= '0;
				div_cnt_q <= hria_pkg::DIV_STEPS;
			end
			hria_pkg::OP_DIV: begin
				rem_q <= rem_ge ? rem_shift - {1'b0, dvs_q} : rem_shift;
				dvd_q <= {dvd_q[hria_pkg::DVD_W-2:0], rem_ge};
				div_cnt_q <= div_cnt_q - hria_pkg::DCNT_W'(1);
			end
			hria_pkg::OP_STORE: begin
				ring_q[ring_idx_q] <= dvd_q[15:8];
				sum_q <= '0;
				sum_idx_q <= '0;
			end
			hria_pkg::OP_SUM: begin
				sum_q <= sum_q + SUM_W'(ring_q[sum_idx_q]);
				sum_idx_q <= sum_idx_q + IDX_W'(1);
			end
			hria_pkg::OP_LOAD_AVG: begin
				dvd_q <= hria_pkg::DVD_W'(sum_q);
				dvs_q <= hria_pkg::DVS_W'(filled_q);
				rem_q <= '0;
				div_cnt_q <= hria_pkg::DIV_STEPS;
			end
			hria_pkg::OP_FINISH: begin
				if (finish_go) begin
					out_present_q <= present;
					out_accepted_q <= accepted_q;
					out_bpm_q <= present ? bpm_q : '0;
					out_avg_q <= present ? avg_q : '0;
				end
			end
			default: begin
			end
		endcase
	end

	// Result channel.
	assign results.valid = out_valid_q;
	assign results.finger_present = out_present_q;
	assign results.beat_accepted = out_accepted_q;
	assign results.bpm_q8 = out_bpm_q;
	assign results.average_bpm = out_avg_q;

endmodule

>>> design/hria_checker.sv
// Port-level checker for heart_rate_interval_averager, attached by bind.
// Depends on hria_pkg for field widths.
module hria_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        finger_present,
	input logic                        beat_accepted,
	input logic [hria_pkg::BPM_W-1:0]  bpm_q8,
	input logic [hria_pkg::AVG_W-1:0]  average_bpm
);

	// A waiting result is not withdrawn.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before it was taken");

	// One item is worked on at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while the previous one is at work");

	// With no finger, the history reads as cleared.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !finger_present |-> bpm_q8 == '0 && average_bpm == '0)
		else $error("rate shown although no finger is present");

	// A kept beat with a finger present shows a rate and average of at least 30 bpm.
	a_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && finger_present && beat_accepted |->
		bpm_q8 >= 16'd7680 && average_bpm >= 8'd30)
		else $error("kept beat with out-of-range rate or average");

endmodule

bind heart_rate_interval_averager hria_checker u_hria_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (samples.valid),
	.in_ready       (samples.ready),
	.out_valid      (results.valid),
	.out_ready      (results.ready),
	.finger_present (results.finger_present),
	.beat_accepted  (results.beat_accepted),
	.bpm_q8         (results.bpm_q8),
	.average_bpm    (results.average_bpm)
);
